// ===== src/ascii_integer_parser_assert.svh =====
// Assertion macros shared by the ASCII integer parser RTL.
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define AIP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define AIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/aip_pkg.sv =====
// Package with the types, codes and constants of the ASCII integer parser.
`timescale 1ns / 1ps

package aip_pkg;

    // Widths of the result and of the internal value and offset counters.
    localparam int VALUE_WIDTH       = 64;
    localparam int OFFSET_WIDTH      = 16;
    localparam int RESULT_WIDTH      = 64;
    localparam int END_OFFSET_WIDTH  = 16;
    localparam int STATUS_WIDTH      = 2;
    localparam int CHAR_WIDTH        = 8;
    localparam int DIGIT_WIDTH       = 6;
    localparam int BASE_WIDTH        = 6;
    localparam int CFG_INDEX_WIDTH   = 4;
    localparam int CFG_DATA_WIDTH    = 8;
    localparam int MAX_RADIX         = 36;

    // Queue between the classifier and the parse engine.
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    // Digit value given to a byte that is no alphanumeric character.
    localparam logic [DIGIT_WIDTH-1:0] NOT_DIGIT = '1;

    // Reset values of the configuration registers.
    localparam logic [BASE_WIDTH-1:0] BASE_RESET   = 6'd10;
    localparam logic                  SIGNED_RESET = 1'b1;

    // Character codes.
    localparam logic [CHAR_WIDTH-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_FF      = 8'h0C;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2D;

    // Radix values used by the base detection.
    localparam logic [BASE_WIDTH-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [BASE_WIDTH-1:0] RADIX_BAD   = 6'd1;
    localparam logic [BASE_WIDTH-1:0] RADIX_OCT   = 6'd8;
    localparam logic [BASE_WIDTH-1:0] RADIX_DEC   = 6'd10;
    localparam logic [BASE_WIDTH-1:0] RADIX_HEX   = 6'd16;
    localparam logic [BASE_WIDTH-1:0] RADIX_LIMIT = 6'd36;

    // Parse phases of the back end.
    typedef enum logic [2:0] {
        PH_DONE       = 3'd0,
        PH_SPACE      = 3'd1,
        PH_AFTER_SIGN = 3'd2,
        PH_ZERO       = 3'd3,
        PH_XSEEN      = 3'd4,
        PH_DIGITS     = 3'd5
    } phase_t;

    // Result status codes.
    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_NUMBER_BASE = 4'd0,
        CFG_SIGNED_MODE = 4'd1
    } cfg_index_t;

    // One classified byte, as queued between the front and the back end.
    typedef struct packed {
        logic                   first;
        logic [DIGIT_WIDTH-1:0] digit;
        logic                   alnum;
        logic                   space;
        logic                   plus;
        logic                   minus;
        logic                   zero;
        logic                   letter_x;
        logic [BASE_WIDTH-1:0]  base;
        logic                   signed_mode;
        logic                   base_bad;
    } item_t;

endpackage

// ===== src/aip_if.sv =====
// Channel interfaces of the ASCII integer parser: bytes, results and configuration.
`timescale 1ns / 1ps

// Byte channel.
interface aip_in_if import aip_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] char_byte;
    logic                  first_of_string;

    modport source (output valid, output char_byte, output first_of_string, input ready);
    modport sink (input valid, input char_byte, input first_of_string, output ready);
endinterface

// Result channel.
interface aip_out_if import aip_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [RESULT_WIDTH-1:0]     parsed_value;
    logic [STATUS_WIDTH-1:0]     parse_status;
    logic [END_OFFSET_WIDTH-1:0] end_offset;

    modport source (output valid, output parsed_value, output parse_status,
                    output end_offset, input ready);
    modport sink (input valid, input parsed_value, input parse_status,
                  input end_offset, output ready);
endinterface

// Configuration write channel.
interface aip_cfg_if import aip_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] reg_index;
    logic [CFG_DATA_WIDTH-1:0]  write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== src/aip_front.sv =====
// Front end: configuration registers and classification of incoming bytes.
`timescale 1ns / 1ps

module aip_front import aip_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    aip_in_if.sink        char_stream,
    aip_cfg_if.sink       cfg,
    output logic          item_valid,
    output item_t         item,
    input  logic          item_ready
);

    logic [BASE_WIDTH-1:0] base_reg;
    logic                  signed_reg;
    logic [CHAR_WIDTH-1:0] c;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_RESET;
            signed_reg <= SIGNED_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.reg_index == CFG_NUMBER_BASE)
            begin
                base_reg <= cfg.write_data[BASE_WIDTH-1:0];
            end
            if (cfg.reg_index == CFG_SIGNED_MODE)
            begin
                signed_reg <= cfg.write_data[0];
            end
        end
    end

    // Bytes pass straight into the queue; the queue decides acceptance.
    assign item_valid        = char_stream.valid;
    assign char_stream.ready = item_ready;
    assign c                 = char_stream.char_byte;

    // Classify the byte and attach the configuration seen at this transaction.
    always_comb
    begin
        item.first    = char_stream.first_of_string;
        item.space    = (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF)
                        || (c == CH_TAB) || (c == CH_FF);
        item.plus     = (c == CH_PLUS);
        item.minus    = (c == CH_MINUS);
        item.zero     = (c == CH_DIGIT_0);
        item.letter_x = (c == CH_LOWER_X) || (c == CH_UPPER_X);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
        begin
            item.digit = DIGIT_WIDTH'(c - CH_DIGIT_0);
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            item.digit = DIGIT_WIDTH'(c - CH_LOWER_A + 8'd10);
        end
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            item.digit = DIGIT_WIDTH'(c - CH_UPPER_A + 8'd10);
        end
        else
        begin
            item.digit = NOT_DIGIT;
        end
        item.alnum       = (item.digit != NOT_DIGIT);
        item.base        = base_reg;
        item.signed_mode = signed_reg;
        item.base_bad    = (base_reg == RADIX_BAD) || (base_reg > RADIX_LIMIT);
    end

endmodule

// ===== src/aip_queue.sv =====
// Short queue of classified bytes between the front and the back end.
`timescale 1ns / 1ps

module aip_queue import aip_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    input  item_t                        push_item,
    output logic                         push_ready,
    output logic                         pop_valid,
    output item_t                        pop_item,
    input  logic                         pop_ready,
    output logic [QUEUE_COUNT_WIDTH-1:0] count
);

    item_t                        slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_next;
    logic [QUEUE_COUNT_WIDTH-1:0] count_reg;
    logic [QUEUE_COUNT_WIDTH-1:0] count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg < QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/aip_back.sv =====
// Back end: parse state machine, accumulator and registered result.
`timescale 1ns / 1ps

module aip_back import aip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  item_t     item,
    output logic      item_ready,
    aip_out_if.source result
);

    localparam int PROD_WIDTH = VALUE_WIDTH + BASE_WIDTH;
    localparam logic [VALUE_WIDTH-1:0] VALUE_MASK = '1;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [BASE_WIDTH-1:0]   base_reg;
    logic [BASE_WIDTH-1:0]   base_next;
    logic [VALUE_WIDTH-1:0]  acc_reg;
    logic [VALUE_WIDTH-1:0]  acc_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    sgn_reg;
    logic                    sgn_next;
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;

    logic                        out_valid_reg;
    logic [VALUE_WIDTH-1:0]      out_value_reg;
    status_t                     out_status_reg;
    logic [OFFSET_WIDTH-1:0]     out_offset_reg;

    logic                    take;
    logic                    emit;
    logic [VALUE_WIDTH-1:0]  res_value;
    status_t                 res_status;
    logic [OFFSET_WIDTH-1:0] res_offset;
    logic                    hold;
    logic                    xbump;
    logic                    do_cand;
    logic                    do_digit;
    logic [BASE_WIDTH-1:0]   cur_base;
    logic [BASE_WIDTH-1:0]   cand_base;
    logic                    cand_zero;
    logic [BASE_WIDTH-1:0]   step_base;
    logic [VALUE_WIDTH-1:0]  lim;
    logic [PROD_WIDTH-1:0]   prod;
    logic                    ovf_hit;
    logic [VALUE_WIDTH-1:0]  ok_value;
    logic [OFFSET_WIDTH-1:0] pos_base;
    logic [OFFSET_WIDTH-1:0] pos_bumped;

    // Saturating increment of the byte position.
    function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] p);
        sat_inc = (p == '1) ? p : p + 1'b1;
    endfunction

    // A byte is taken whenever the result register is free or being emptied.
    assign take       = item_valid && item_ready;
    assign item_ready = !out_valid_reg || result.ready;

    // Candidate digit: automatic base resolves to decimal unless a '0' leads.
    assign cur_base  = item.first ? item.base : base_reg;
    assign cand_base = (cur_base == RADIX_AUTO && !item.zero) ? RADIX_DEC : cur_base;
    assign cand_zero = (cand_base == RADIX_AUTO) || (cand_base == RADIX_HEX && item.zero);

    // One multiply-add and a compare against the signed or unsigned limit.
    assign step_base = (base_reg == RADIX_AUTO) ? RADIX_OCT : base_reg;
    assign lim       = sgn_reg ? ((VALUE_MASK >> 1) + VALUE_WIDTH'(neg_reg)) : VALUE_MASK;
    assign prod      = PROD_WIDTH'(acc_reg) * PROD_WIDTH'(step_base)
                       + PROD_WIDTH'(item.digit);
    assign ovf_hit   = (prod > PROD_WIDTH'(lim));
    assign ok_value  = neg_reg ? (~acc_reg + 1'b1) : acc_reg;

    // Next parse state and the result that this byte gives, if any.
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        sgn_next   = sgn_reg;
        emit       = 1'b0;
        res_value  = '0;
        res_status = ST_OK;
        res_offset = pos_reg;
        hold       = 1'b0;
        xbump      = 1'b0;
        do_cand    = 1'b0;
        do_digit   = 1'b0;

        if (item.first)
        begin
            neg_next  = 1'b0;
            acc_next  = '0;
            ovf_next  = 1'b0;
            sgn_next  = item.signed_mode;
            base_next = item.base;
            if (item.base_bad)
            begin
                emit       = 1'b1;
                res_status = ST_INVALID;
                res_offset = '0;
                phase_next = PH_DONE;
            end
            else if (item.alnum)
            begin
                do_cand = 1'b1;
            end
            else if (item.space)
            begin
                phase_next = PH_SPACE;
            end
            else if (item.plus || item.minus)
            begin
                neg_next   = item.minus;
                phase_next = PH_AFTER_SIGN;
            end
            else
            begin
                do_cand = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SPACE:
                begin
                    if (item.space)
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (item.plus || item.minus)
                    begin
                        neg_next   = item.minus;
                        phase_next = PH_AFTER_SIGN;
                    end
                    else
                    begin
                        do_cand = 1'b1;
                    end
                end
                PH_AFTER_SIGN:
                begin
                    do_cand = 1'b1;
                end
                PH_ZERO:
                begin
                    acc_next = '0;
                    if (item.letter_x)
                    begin
                        base_next  = RADIX_HEX;
                        phase_next = PH_XSEEN;
                        hold       = 1'b1;
                    end
                    else
                    begin
                        base_next  = step_base;
                        phase_next = PH_DIGITS;
                        do_digit   = 1'b1;
                    end
                end
                PH_XSEEN:
                begin
                    if (item.digit < RADIX_HEX)
                    begin
                        acc_next   = VALUE_WIDTH'(item.digit);
                        phase_next = PH_DIGITS;
                        xbump      = 1'b1;
                    end
                    else
                    begin
                        // Dangling hex prefix: the value is the leading zero.
                        acc_next   = '0;
                        emit       = 1'b1;
                        res_value  = '0;
                        res_status = ST_OK;
                        res_offset = pos_reg;
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    do_digit = 1'b1;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        // First candidate digit after whitespace and sign.
        if (do_cand)
        begin
            base_next = cand_base;
            if (cand_zero)
            begin
                phase_next = PH_ZERO;
            end
            else if (item.digit >= cand_base)
            begin
                emit       = 1'b1;
                res_status = ST_INVALID;
                res_offset = '0;
                phase_next = PH_DONE;
            end
            else
            begin
                acc_next   = VALUE_WIDTH'(item.digit);
                phase_next = PH_DIGITS;
            end
        end

        // Digit after at least one accepted digit.
        if (do_digit)
        begin
            if (item.digit >= step_base)
            begin
                emit       = 1'b1;
                res_offset = pos_reg;
                phase_next = PH_DONE;
                if (ovf_reg)
                begin
                    res_status = ST_RANGE;
                    res_value  = '0;
                end
                else
                begin
                    res_status = ST_OK;
                    res_value  = ok_value;
                end
            end
            else if (!ovf_reg)
            begin
                if (ovf_hit)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = prod[VALUE_WIDTH-1:0];
                end
            end
        end
    end

    // Byte position: reset at a first byte, held on the 'x' of a hex prefix.
    always_comb
    begin
        pos_base   = item.first ? '0 : pos_reg;
        pos_bumped = xbump ? sat_inc(pos_base) : pos_base;
        pos_next   = (phase_next != PH_DONE && !hold) ? sat_inc(pos_bumped) : pos_bumped;
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            sgn_reg   <= SIGNED_RESET;
            pos_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            sgn_reg   <= sgn_next;
            pos_reg   <= pos_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_offset_reg <= res_offset;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.parsed_value = RESULT_WIDTH'(out_value_reg);
    assign result.parse_status = out_status_reg;
    assign result.end_offset   = END_OFFSET_WIDTH'(out_offset_reg);

endmodule

// ===== src/ascii_integer_parser.sv =====
// Top level of the ASCII integer parser: classifier, byte queue and parse engine.
// A terminating byte is registered in a queue slot, then its result in the result register.
// Throughput: one byte per cycle; a byte passes through the queue, then one multiply-add
// and limit compare in the parse engine; a stalled result fills the queue, then stalls input.
// Reset: rst_n is asynchronous, active low; it empties the queue and the result register,
// leaves the parser waiting for a first byte, and sets number_base 10 and signed_mode 1.
`timescale 1ns / 1ps
`include "ascii_integer_parser_assert.svh"

module ascii_integer_parser import aip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    aip_in_if.sink    char_stream,
    aip_cfg_if.sink   cfg,
    aip_out_if.source result
);

    item_t                        front_item;
    logic                         front_valid;
    logic                         front_ready;
    item_t                        head_item;
    logic                         head_valid;
    logic                         head_ready;
    logic [QUEUE_COUNT_WIDTH-1:0] q_count;
    logic                         q_push;
    logic                         q_pop;

    // Byte classification and configuration registers.
    aip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_stream),
        .cfg         (cfg),
        .item_valid  (front_valid),
        .item        (front_item),
        .item_ready  (front_ready)
    );

    // Queue that decouples byte acceptance from parsing.
    aip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_item  (front_item),
        .push_ready (front_ready),
        .pop_valid  (head_valid),
        .pop_item   (head_item),
        .pop_ready  (head_ready),
        .count      (q_count)
    );

    // Parse engine with the result register.
    aip_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (head_valid),
        .item       (head_item),
        .item_ready (head_ready),
        .result     (result)
    );

    assign q_push = front_valid && front_ready;
    assign q_pop  = head_valid && head_ready;

    // Queue bookkeeping checks.
    `AIP_ASSERT_SAME(a_queue_bound, 1'b1, q_count <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH), "queue over depth")
    `AIP_ASSERT_SAME(a_pop_nonempty, q_pop, q_count != '0, "parse engine took from an empty queue")
    `AIP_ASSERT_NEXT(a_count_up, q_push && !q_pop, q_count == $past(q_count) + 1'b1, "queue count missed a push")
    `AIP_ASSERT_NEXT(a_count_down, q_pop && !q_push, q_count == $past(q_count) - 1'b1, "queue count missed a pop")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for ascii_integer_parser with a built-in string-to-integer predictor.
`timescale 1ns / 1ps

module tb;

    import aip_pkg::*;

    localparam int NO_DIGIT       = 99;
    localparam int STALL_LIMIT    = 1000;

    // One byte of the input stream.
    typedef struct {
        logic [CHAR_WIDTH-1:0] char_byte;
        logic                  first;
    } char_item_t;

    // One parse result as seen on the result channel.
    typedef struct {
        logic [RESULT_WIDTH-1:0]     value;
        status_t                     status;
        logic [END_OFFSET_WIDTH-1:0] offset;
    } parse_result_t;

    logic clk;
    logic rst_n;

    aip_in_if  char_stream_if();
    aip_cfg_if cfg_if();
    aip_out_if result_if();

    ascii_integer_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_stream_if),
        .cfg         (cfg_if),
        .result      (result_if)
    );

    // Stimulus and scoreboard storage.
    char_item_t    pending_chars[$];
    parse_result_t expected_results[$];
    int            items_queued = 0;
    int            items_taken  = 0;
    int            error_count  = 0;
    int            idle_odds    = 8;
    bit            quiet        = 1'b0;
    int            send_gap     = 0;
    int            stall_left   = 0;
    int            idle_cycles  = 0;

    // Shadow copies of the configuration registers.
    logic [BASE_WIDTH-1:0] base_shadow   = RADIX_DEC;
    bit                    signed_shadow = 1'b1;

    // Parser state as predicted by the testbench.
    phase_t                      phase     = PH_DONE;
    bit                          neg       = 1'b0;
    logic [BASE_WIDTH-1:0]       cur_base  = '0;
    logic [VALUE_WIDTH-1:0]      acc       = '0;
    bit                          ovf       = 1'b0;
    logic [OFFSET_WIDTH-1:0]     pos       = '0;
    bit                          sgn_latch = 1'b1;
    parse_result_t               finished_result;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Character classification.
    function automatic int digit_value(logic [CHAR_WIDTH-1:0] c);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            return int'(c - CH_DIGIT_0);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return int'(c - CH_LOWER_A) + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return int'(c - CH_UPPER_A) + 10;
        return NO_DIGIT;
    endfunction

    function automatic bit is_blank(logic [CHAR_WIDTH-1:0] c);
        return c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_FF;
    endfunction

    function automatic bit is_sign(logic [CHAR_WIDTH-1:0] c);
        return c == CH_MINUS || c == CH_PLUS;
    endfunction

    // Closes the current string with the given result.
    function automatic bit finish_parse(logic [VALUE_WIDTH-1:0] v, status_t st,
                                        logic [OFFSET_WIDTH-1:0] off);
        finished_result.value  = v;
        finished_result.status = st;
        finished_result.offset = off;
        phase = PH_DONE;
        return 1'b1;
    endfunction

    function automatic bit finish_ok();
        return finish_parse(neg ? (64'd0 - acc) : acc, ST_OK, pos);
    endfunction

    // A byte after at least one accepted digit: accumulate or terminate.
    function automatic bit digit_step(logic [CHAR_WIDTH-1:0] c);
        int                     d;
        logic [VALUE_WIDTH-1:0] lim;
        d = digit_value(c);
        if (d >= cur_base)
        begin
            if (ovf)
                return finish_parse('0, ST_RANGE, pos);
            return finish_ok();
        end
        if (ovf)
            return 1'b0;
        if (sgn_latch)
            lim = {1'b0, {(VALUE_WIDTH-1){1'b1}}} + VALUE_WIDTH'(neg);
        else
            lim = '1;
        if (acc > (lim - VALUE_WIDTH'(d)) / VALUE_WIDTH'(cur_base))
            ovf = 1'b1;
        else
            acc = acc * cur_base + VALUE_WIDTH'(d);
        return 1'b0;
    endfunction

    // First byte that may be a digit, after any blanks and sign.
    function automatic bit first_digit(logic [CHAR_WIDTH-1:0] c);
        int d;
        d = digit_value(c);
        if (cur_base == RADIX_AUTO && c != CH_DIGIT_0)
            cur_base = RADIX_DEC;
        if (cur_base == RADIX_AUTO || (cur_base == RADIX_HEX && c == CH_DIGIT_0))
        begin
            phase = PH_ZERO;
            return 1'b0;
        end
        if (d >= cur_base)
            return finish_parse('0, ST_INVALID, '0);
        acc   = VALUE_WIDTH'(d);
        phase = PH_DIGITS;
        return 1'b0;
    endfunction

    // Advances the predicted parser by one byte; returns 1 when a result is due.
    function automatic bit parse_step(logic [CHAR_WIDTH-1:0] c, logic first,
                                      output parse_result_t r);
        bit emitted;
        bit hold;
        emitted = 1'b0;
        hold    = 1'b0;
        if (first)
        begin
            neg       = 1'b0;
            acc       = '0;
            ovf       = 1'b0;
            pos       = '0;
            cur_base  = base_shadow;
            sgn_latch = signed_shadow;
            if (cur_base == RADIX_BAD || cur_base > RADIX_LIMIT)
            begin
                emitted = finish_parse('0, ST_INVALID, '0);
            end
            else if (digit_value(c) != NO_DIGIT)
                emitted = first_digit(c);
            else if (is_blank(c))
                phase = PH_SPACE;
            else if (is_sign(c))
            begin
                neg   = (c == CH_MINUS);
                phase = PH_AFTER_SIGN;
            end
            else
                emitted = first_digit(c);
        end
        else
        begin
            case (phase)
                PH_SPACE:
                begin
                    if (is_sign(c))
                    begin
                        neg   = (c == CH_MINUS);
                        phase = PH_AFTER_SIGN;
                    end
                    else if (!is_blank(c))
                        emitted = first_digit(c);
                end
                PH_AFTER_SIGN:
                    emitted = first_digit(c);
                PH_ZERO:
                begin
                    acc = '0;
                    if (c == CH_LOWER_X || c == CH_UPPER_X)
                    begin
                        cur_base = RADIX_HEX;
                        phase    = PH_XSEEN;
                        hold     = 1'b1;
                    end
                    else
                    begin
                        if (cur_base == RADIX_AUTO)
                            cur_base = RADIX_OCT;
                        phase   = PH_DIGITS;
                        emitted = digit_step(c);
                    end
                end
                PH_XSEEN:
                begin
                    // A dangling prefix ends as zero with the offset at the x.
                    if (digit_value(c) < 16)
                    begin
                        acc   = VALUE_WIDTH'(digit_value(c));
                        phase = PH_DIGITS;
                        if (pos != '1)
                            pos++;
                    end
                    else
                    begin
                        acc     = '0;
                        emitted = finish_ok();
                    end
                end
                PH_DIGITS:
                    emitted = digit_step(c);
                default:
                    phase = PH_DONE;
            endcase
        end
        if (phase != PH_DONE && !hold && pos != '1)
            pos++;
        r = finished_result;
        return emitted;
    endfunction

    // Stimulus helpers.
    task automatic add_byte(logic [CHAR_WIDTH-1:0] c, bit first);
        char_item_t it;
        it.char_byte = c;
        it.first     = first;
        pending_chars.push_back(it);
        items_queued++;
    endtask

    task automatic add_text(string s, bit starts);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], starts && i == 0);
    endtask

    function automatic logic [CHAR_WIDTH-1:0] digit_char(int d);
        if (d < 10)
            return CH_DIGIT_0 + CHAR_WIDTH'(d);
        return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + CHAR_WIDTH'(d - 10);
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] stop_char(int radix);
        logic [CHAR_WIDTH-1:0] c;
        do
            c = CHAR_WIDTH'($urandom_range(0, 255));
        while (digit_value(c) < radix);
        return c;
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] blank_char();
        case ($urandom_range(0, 4))
            0: return CH_SPACE;
            1: return CH_CR;
            2: return CH_LF;
            3: return CH_TAB;
            default: return CH_FF;
        endcase
    endfunction

    // Random bytes forming a string that is mostly not a number.
    task automatic add_noise();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            add_byte(CHAR_WIDTH'($urandom_range(0, 255)), i == 0);
    endtask

    // A mostly well-formed number string for the current configuration.
    task automatic add_number_string();
        logic [CHAR_WIDTH-1:0] text[$];
        int                    digits[$];
        int                    radix;
        int                    lead;
        int                    kind;
        bit                    minus;
        bit                    hex_prefix;
        bit                    oct_zero;
        bit                    dangling;
        logic [64:0]           mag;
        logic [64:0]           lim;
        radix      = base_shadow;
        minus      = 1'b0;
        hex_prefix = 1'b0;
        oct_zero   = 1'b0;
        dangling   = 1'b0;
        mag        = '0;
        if (base_shadow == RADIX_AUTO)
        begin
            case ($urandom_range(0, 2))
                0: radix = 10;
                1:
                begin
                    radix    = 8;
                    oct_zero = 1'b1;
                end
                default:
                begin
                    radix      = 16;
                    hex_prefix = 1'b1;
                end
            endcase
        end
        else if (base_shadow == RADIX_BAD || base_shadow > RADIX_LIMIT)
            radix = $urandom_range(2, 36);
        else if (base_shadow == RADIX_HEX)
            hex_prefix = ($urandom_range(0, 2) == 0);

        // Leading blanks and sign.
        lead = $urandom_range(0, 3);
        if (lead[0])
            repeat ($urandom_range(1, 3)) text.push_back(blank_char());
        if (lead[1])
        begin
            minus = 1'($urandom_range(0, 1));
            text.push_back(minus ? CH_MINUS : CH_PLUS);
        end
        if (hex_prefix)
        begin
            text.push_back(CH_DIGIT_0);
            text.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            dangling = ($urandom_range(0, 7) == 0);
        end
        if (oct_zero)
            text.push_back(CH_DIGIT_0);

        // Digit body: short, at the range limit, full width, long, zero padded or empty.
        kind = dangling ? 9 : $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3:
                repeat ($urandom_range(1, 6)) digits.push_back($urandom_range(0, radix - 1));
            4, 5:
            begin
                if (signed_shadow)
                    lim = minus ? (65'd1 << 63) : (65'd1 << 63) - 65'd1;
                else
                    lim = (65'd1 << 64) - 65'd1;
                mag = lim - 65'd1 + 65'($urandom_range(0, 2));
            end
            6:
                mag = {1'b0, $urandom, $urandom};
            7:
                repeat ($urandom_range(20, 70)) digits.push_back($urandom_range(0, radix - 1));
            8:
            begin
                repeat ($urandom_range(1, 4)) digits.push_back(0);
                repeat ($urandom_range(1, 3)) digits.push_back($urandom_range(0, radix - 1));
            end
            default:
                ;
        endcase
        if (kind >= 4 && kind <= 6)
        begin
            do
            begin
                digits.push_front(int'(mag % radix));
                mag = mag / radix;
            end
            while (mag != 0);
        end
        foreach (digits[i])
            text.push_back(digit_char(digits[i]));

        // Usually a terminator, then bytes that a finished parse ignores.
        if ($urandom_range(0, 9) != 0)
            text.push_back(stop_char(radix));
        repeat ($urandom_range(0, 2)) text.push_back(CHAR_WIDTH'($urandom_range(0, 255)));
        if (text.size() == 0)
            text.push_back(stop_char(radix));
        foreach (text[i])
            add_byte(text[i], i == 0);
    endtask

    task automatic run_random(int quota);
        int start;
        start = items_queued;
        case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 4;
            default: idle_odds = 8;
        endcase
        while (items_queued - start < quota)
        begin
            if ($urandom_range(0, 7) == 0)
                add_noise();
            else
                add_number_string();
        end
    endtask

    // Waits until every byte is taken and every result has arrived.
    task automatic drain();
        while (items_taken != items_queued || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes both configuration registers back to back; unused data bits are random.
    task automatic write_config(logic [BASE_WIDTH-1:0] base, bit sgn);
        cfg_if.valid      <= 1'b1;
        cfg_if.reg_index  <= CFG_NUMBER_BASE;
        cfg_if.write_data <= {2'($urandom_range(0, 3)), base};
        do
            @(posedge clk);
        while (!cfg_if.ready);
        base_shadow = base;
        cfg_if.reg_index  <= CFG_SIGNED_MODE;
        cfg_if.write_data <= {7'($urandom_range(0, 127)), sgn};
        do
            @(posedge clk);
        while (!cfg_if.ready);
        signed_shadow = sgn;
        cfg_if.valid <= 1'b0;
    endtask

    // Byte driver: predicts on every accepted transaction, then offers the next byte.
    always @(posedge clk)
    begin : char_driver
        char_item_t    nxt;
        parse_result_t res;
        if (!rst_n)
        begin
            char_stream_if.valid           <= 1'b0;
            char_stream_if.char_byte       <= '0;
            char_stream_if.first_of_string <= 1'b0;
        end
        else
        begin
            if (char_stream_if.valid && char_stream_if.ready)
            begin
                if (parse_step(char_stream_if.char_byte, char_stream_if.first_of_string, res))
                    expected_results.push_back(res);
                items_taken++;
            end
            if (!char_stream_if.valid || char_stream_if.ready)
            begin
                if (send_gap > 0)
                begin
                    char_stream_if.valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_chars.size() != 0 && !quiet && idle_odds != 0
                         && $urandom_range(1, idle_odds) == 1)
                begin
                    char_stream_if.valid <= 1'b0;
                    send_gap = $urandom_range(0, 2);
                end
                else if (pending_chars.size() != 0)
                begin
                    nxt = pending_chars.pop_front();
                    char_stream_if.valid           <= 1'b1;
                    char_stream_if.char_byte       <= nxt.char_byte;
                    char_stream_if.first_of_string <= nxt.first;
                end
                else
                    char_stream_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each transaction with the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        parse_result_t want;
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result value %h status %0d offset %0d", $time,
                             result_if.parsed_value, result_if.parse_status, result_if.end_offset);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_if.parsed_value !== want.value)
                    begin
                        $display("%0t: parsed_value expected %h actual %h", $time,
                                 want.value, result_if.parsed_value);
                        error_count++;
                    end
                    if (result_if.parse_status !== want.status)
                    begin
                        $display("%0t: parse_status expected %0d actual %0d", $time,
                                 want.status, result_if.parse_status);
                        error_count++;
                    end
                    if (result_if.end_offset !== want.offset)
                    begin
                        $display("%0t: end_offset expected %0d actual %0d", $time,
                                 want.offset, result_if.end_offset);
                        error_count++;
                    end
                end
            end

            // Back-pressure in short bursts.
            if (stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                result_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_stream_if.valid && char_stream_if.ready)
                || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin : test_sequence
        int                    plan_base[16] = '{16, 0, 0, 2, 36, 36, 8, 1, 63, 37, 10, 3,
                                                 0, 0, 0, 2};
        bit                    plan_sgn[16]  = '{0, 1, 0, 1, 0, 1, 1, 1, 0, 1, 0, 0,
                                                 0, 0, 0, 0};
        logic [BASE_WIDTH-1:0] base;
        bit                    sgn;

        char_stream_if.valid           = 1'b0;
        char_stream_if.char_byte       = '0;
        char_stream_if.first_of_string = 1'b0;
        cfg_if.valid                   = 1'b0;
        cfg_if.reg_index               = CFG_NUMBER_BASE;
        cfg_if.write_data              = '0;
        result_if.ready                = 1'b0;
        rst_n                          = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings under the reset configuration (decimal, signed).
        add_byte(CH_TAB, 1'b1);
        add_text("-42 ", 1'b0);
        add_text("z", 1'b1);
        add_text(" +", 1'b1);
        add_text("99x", 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_text("0", 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(CH_CR, 1'b1);
        add_byte(CH_FF, 1'b0);
        add_text("5", 1'b0);
        add_byte(8'h80, 1'b0);
        run_random(70);

        // Random strings under a series of settings, including invalid radices.
        for (int i = 0; i < 16; i++)
        begin
            base = BASE_WIDTH'(plan_base[i]);
            sgn  = plan_sgn[i];
            if (i >= 12 && i <= 14)
            begin
                base = BASE_WIDTH'($urandom_range(0, 63));
                sgn  = 1'($urandom_range(0, 1));
            end
            drain();
            write_config(base, sgn);
            run_random((base == RADIX_BAD || base > RADIX_LIMIT) ? 30 : 70);
        end

        // Closing stretch with no idling on either side.
        drain();
        write_config(RADIX_AUTO, 1'b1);
        quiet = 1'b1;
        run_random(150);
        drain();
        repeat (16) @(posedge clk);

        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
